// ===== hdl/point_segment_distance_unit_macros.svh =====
`ifndef POINT_SEGMENT_DISTANCE_UNIT_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define PSD_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("psd check failed");

// next-cycle implication, off during reset
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("psd check failed");

// next-cycle implication, live through reset
`define PSD_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("psd reset check failed");

`endif

// ===== hdl/psd_pkg.sv =====
`default_nettype none
package psd_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIST_BITS  = 25;
    localparam int CFG_IDX_BITS = 4;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int RW_A = 4 * DW + 2;
    localparam int RW_B = PW + 2 * DIST_BITS + 2;
    localparam int RW = (RW_A > RW_B) ? RW_A : RW_B;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_X = 4'd0,
        REG_START_Y = 4'd1,
        REG_END_X   = 4'd2,
        REG_END_Y   = 4'd3
    } psd_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } psd_in_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 outside;
        logic                 degenerate;
    } psd_out_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } psd_seg_t;

    typedef struct packed {
        logic                 valid;
        logic [RW-1:0]        rem;
        logic [RW-1:0]        acc;
        logic [PW-1:0]        len2;
        logic [DIST_BITS-1:0] root;
        logic                 outside;
        logic                 degenerate;
    } psd_root_t;

endpackage
`default_nettype wire

// ===== hdl/point_segment_distance_unit.sv =====
`default_nettype none
// Point to segment distance: the segment endpoints sit in four config
// registers (0 start_x, 1 start_y, 2 end_x, 3 end_y; other indexes ignored),
// each query point word returns one result word with the truncated distance
// to its projection, or the outside or degenerate flag with distance 0.
// A new point is taken every cycle while the output is not stalled; the
// pipeline is six stages of offset, products, sums and squaring of the
// cross product, then a 25-stage shift-and-subtract root recurrence, one
// stage per result bit, then the output register. A stall on m_ready holds the whole pipeline.
module point_segment_distance_unit import psd_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire psd_in_t                 s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output psd_out_t                     m_data,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [COORD_BITS-1:0]   cfg_data
);

    psd_seg_t  seg_reg;
    psd_root_t root_word;
    logic      en;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_START_X: seg_reg.start_x <= cfg_data;
                REG_START_Y: seg_reg.start_y <= cfg_data;
                REG_END_X:   seg_reg.end_x   <= cfg_data;
                REG_END_Y:   seg_reg.end_y   <= cfg_data;
                default: ;
            endcase
        end
    end

    psd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .seg       (seg_reg),
        .root_word (root_word)
    );

    psd_root u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .root_in   (root_word),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

endmodule
`default_nettype wire

// ===== hdl/psd_front.sv =====
`default_nettype none
module psd_front import psd_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire psd_in_t   in_data,
    input  wire psd_seg_t  seg,
    output psd_root_t      root_word
);

    logic signed [DW-1:0] d_x, d_y;
    assign d_x = DW'(seg.end_x) - DW'(seg.start_x);
    assign d_y = DW'(seg.end_y) - DW'(seg.start_y);

    // stage 1
    logic                 v1_reg;
    logic signed [DW-1:0] qx_reg, qy_reg;
    // stage 2
    logic                 v2_reg, deg2_reg;
    logic signed [PW-1:0] pxx_reg, pyy_reg, pxy_reg, pyx_reg, sqx_reg, sqy_reg;
    // stage 3
    logic                   v3_reg, deg3_reg;
    logic signed [PW:0]     dot_reg, cross_reg;
    logic [PW-1:0]          len3_reg;
    // stage 4
    logic                 v4_reg, deg4_reg, out4_reg;
    logic [PW-1:0]        cmag_reg, len4_reg;
    // stage 5
    logic                 v5_reg, deg5_reg, out5_reg;
    logic [PW-1:0]        hh_reg, hl_reg, ll_reg, len5_reg;
    // stage 6
    psd_root_t            w6_reg;

    logic signed [PW:0] dot_next, cross_next;
    logic [PW-1:0]      len3_next, cmag_next;
    logic               out4_next;
    logic [RW-1:0]      c2_next;

    assign dot_next   = (PW+1)'(pxx_reg) + (PW+1)'(pyy_reg);
    assign cross_next = (PW+1)'(pxy_reg) - (PW+1)'(pyx_reg);
    assign len3_next  = sqx_reg + sqy_reg;
    assign out4_next  = !deg3_reg &&
                        (dot_reg[PW] || (dot_reg > $signed({1'b0, len3_reg})));
    assign cmag_next  = cross_reg[PW] ? PW'(-cross_reg) : PW'(cross_reg);
    assign c2_next    = (RW'(hh_reg) << (2 * DW)) + (RW'(hl_reg) << (DW + 1))
                      + RW'(ll_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            w6_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            w6_reg.valid <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qx_reg   <= DW'(in_data.point_x) - DW'(seg.start_x);
            qy_reg   <= DW'(in_data.point_y) - DW'(seg.start_y);

            pxx_reg  <= qx_reg * d_x;
            pyy_reg  <= qy_reg * d_y;
            pxy_reg  <= qx_reg * d_y;
            pyx_reg  <= qy_reg * d_x;
            sqx_reg  <= d_x * d_x;
            sqy_reg  <= d_y * d_y;
            deg2_reg <= (d_x == '0) && (d_y == '0);

            dot_reg   <= dot_next;
            cross_reg <= cross_next;
            len3_reg  <= len3_next;
            deg3_reg  <= deg2_reg;

            cmag_reg <= cmag_next;
            len4_reg <= len3_reg;
            out4_reg <= out4_next;
            deg4_reg <= deg3_reg;

            hh_reg   <= cmag_reg[PW-1:DW] * cmag_reg[PW-1:DW];
            hl_reg   <= cmag_reg[PW-1:DW] * cmag_reg[DW-1:0];
            ll_reg   <= cmag_reg[DW-1:0] * cmag_reg[DW-1:0];
            len5_reg <= len4_reg;
            out5_reg <= out4_reg;
            deg5_reg <= deg4_reg;

            w6_reg.rem        <= (out5_reg || deg5_reg) ? '0 : c2_next;
            w6_reg.acc        <= '0;
            w6_reg.len2       <= len5_reg;
            w6_reg.root       <= '0;
            w6_reg.outside    <= out5_reg;
            w6_reg.degenerate <= deg5_reg;
        end
    end

    assign root_word = w6_reg;

endmodule
`default_nettype wire

// ===== hdl/psd_root.sv =====
`default_nettype none
module psd_root import psd_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      en,
    input  wire psd_root_t root_in,
    output logic           out_valid,
    output psd_out_t       out_data
);

    // one result bit per stage, msb first; acc tracks len2 * root
    psd_root_t stage_reg [DIST_BITS+1];
    logic      m_valid_reg;
    psd_out_t  m_data_reg;

    always_comb stage_reg[0] = root_in;

    genvar i;
    generate
        for (i = 0; i < DIST_BITS; i++) begin : g_bit
            localparam int K = DIST_BITS - 1 - i;
            psd_root_t     w_reg;
            logic [RW-1:0] trial, len_w;
            logic          take;

            assign len_w = RW'(stage_reg[i].len2);
            assign trial = (stage_reg[i].acc << (K + 1)) + (len_w << (2 * K));
            assign take  = stage_reg[i].rem >= trial;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    w_reg.valid <= 1'b0;
                end else if (en) begin
                    w_reg.valid <= stage_reg[i].valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    w_reg.rem        <= take ? stage_reg[i].rem - trial : stage_reg[i].rem;
                    w_reg.acc        <= take ? stage_reg[i].acc + (len_w << K)
                                             : stage_reg[i].acc;
                    w_reg.root       <= take ? stage_reg[i].root | (DIST_BITS'(1) << K)
                                             : stage_reg[i].root;
                    w_reg.len2       <= stage_reg[i].len2;
                    w_reg.outside    <= stage_reg[i].outside;
                    w_reg.degenerate <= stage_reg[i].degenerate;
                end
            end

            always_comb stage_reg[i+1] = w_reg;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= stage_reg[DIST_BITS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.distance   <= stage_reg[DIST_BITS].degenerate ? '0
                                   : stage_reg[DIST_BITS].root;
            m_data_reg.outside    <= stage_reg[DIST_BITS].outside;
            m_data_reg.degenerate <= stage_reg[DIST_BITS].degenerate;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== hdl/psd_checker.sv =====
`default_nettype none
`include "point_segment_distance_unit_macros.svh"
module psd_checker import psd_pkg::*; (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire psd_out_t m_data
);

    `PSD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `PSD_ASSERT(a_outside_zero, m_valid && m_data.outside, (m_data.distance == '0) && !m_data.degenerate)
    `PSD_ASSERT(a_degen_zero, m_valid && m_data.degenerate, (m_data.distance == '0) && !m_data.outside)
    `PSD_ASSERT_RST(a_reset_idle, !aresetn, !m_valid)

endmodule

bind point_segment_distance_unit psd_checker u_psd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import psd_pkg::*;

    localparam int LATENCY = 32;
    localparam longint CYCLE_LIMIT = 400000;

    class distance_scoreboard;
        logic signed [COORD_BITS-1:0] seg_ax, seg_ay, seg_bx, seg_by;
        psd_out_t pending[$];
        int errors;

        function new();
            seg_ax = '0; seg_ay = '0; seg_bx = '0; seg_by = '0;
            errors = 0;
        endfunction

        function void set_reg(psd_reg_t idx, logic [COORD_BITS-1:0] val);
            case (idx)
                REG_START_X: seg_ax = val;
                REG_START_Y: seg_ay = val;
                REG_END_X:   seg_bx = val;
                REG_END_Y:   seg_by = val;
                default: ;
            endcase
        endfunction

        function psd_out_t predict(psd_in_t p);
            psd_out_t r;
            logic signed [127:0] dx, dy, qx, qy, len2, dotp, crs, c2, tt, t;
            r = '0;
            dx = seg_bx - seg_ax;
            dy = seg_by - seg_ay;
            qx = p.point_x - seg_ax;
            qy = p.point_y - seg_ay;
            if (dx == 0 && dy == 0) begin
                r.degenerate = 1'b1;
                return r;
            end
            len2 = dx * dx + dy * dy;
            dotp = qx * dx + qy * dy;
            if (dotp < 0 || dotp > len2) begin
                r.outside = 1'b1;
                return r;
            end
            crs = qx * dy - qy * dx;
            if (crs < 0) crs = -crs;
            c2 = crs * crs;
            t = 0;
            for (int b = DIST_BITS - 1; b >= 0; b--) begin
                tt = t | (128'sd1 <<< b);
                if (tt * tt * len2 <= c2) t = tt;
            end
            r.distance = t[DIST_BITS-1:0];
            return r;
        endfunction

        function void note_point(psd_in_t p);
            pending = {pending, predict(p)};
        endfunction

        function void check_result(psd_out_t got);
            psd_out_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.distance !== want.distance || got.outside !== want.outside
                || got.degenerate !== want.degenerate) begin
                $display("%0t: mismatch expected dist=%0d out=%b deg=%b actual dist=%0d out=%b deg=%b",
                         $time, want.distance, want.outside, want.degenerate,
                         got.distance, got.outside, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    psd_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    psd_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [COORD_BITS-1:0] cfg_data = '0;

    distance_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    longint cycles = 0;

    always #5 aclk = ~aclk;

    point_segment_distance_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("point_segment_distance_unit test failed");
            $finish;
        end
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    always @(negedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // config only changes with the pipeline empty
    task automatic write_reg(psd_reg_t idx, logic [COORD_BITS-1:0] val);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_bad_index(logic [COORD_BITS-1:0] val);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= 4'hF;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_segment(logic [COORD_BITS-1:0] ax, ay, bx, by);
        write_reg(REG_START_X, ax);
        write_reg(REG_START_Y, ay);
        write_reg(REG_END_X, bx);
        write_reg(REG_END_Y, by);
    endtask

    // valid stays up for a following word; dropped when idling or stopping
    task automatic send_point(logic [COORD_BITS-1:0] px, py);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{point_x: px, point_y: py};
        do @(posedge aclk); while (!s_ready);
        sb.note_point(s_data);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    function automatic logic [COORD_BITS-1:0] rand_coord(int span);
        if (span >= COORD_BITS) return COORD_BITS'($urandom);
        return COORD_BITS'($signed($urandom_range((1 << span) - 1)) - (1 << (span - 1)));
    endfunction

    task automatic random_points(int n, int span);
        logic [COORD_BITS-1:0] px, py;
        for (int i = 0; i < n; i++) begin
            px = rand_coord(span);
            py = rand_coord(span);
            if ($urandom_range(9) == 0) begin
                px = sb.seg_ax + ((sb.seg_bx - sb.seg_ax) >>> $urandom_range(3));
                py = sb.seg_ay + ((sb.seg_by - sb.seg_ay) >>> $urandom_range(3));
            end
            send_point(px, py);
        end
    endtask

    task automatic random_segment(int span);
        set_segment(rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span));
    endtask

    localparam logic [COORD_BITS-1:0] MAXC = 24'h7FFFFF;
    localparam logic [COORD_BITS-1:0] MINC = 24'h800000;

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset segment is a single point
        send_point(24'h000100, 24'h000200);
        set_segment(24'h000000, 24'h000000, 24'h000A00, 24'h000000);
        send_point(24'h000000, 24'h000500);
        send_point(24'h000A00, 24'h000300);
        send_point(24'h000500, 24'hFFFB00);
        send_point(24'hFFFFFF, 24'h000100);
        send_point(24'h000A01, 24'h000100);
        send_point(MAXC, MAXC);
        send_point(MINC, MINC);
        write_bad_index(24'h123456);
        drain();
        set_segment(MINC, MINC, MAXC, MAXC);
        send_point(MAXC, MINC);
        send_point(MINC, MAXC);
        send_point(24'h000000, 24'h000000);
        send_point(MAXC, MAXC);
        send_point(MINC, MINC);
        send_point(24'hFFFFFF, 24'h000000);
        drain();
        set_segment(MAXC, MINC, MINC, MAXC);
        send_point(MAXC, MAXC);
        send_point(MINC, MINC);
        send_point(24'h555555, 24'hAAAAAA);
        drain();
        set_segment(24'h123456, MAXC, 24'h123456, MAXC);
        send_point(24'h000000, 24'h000000);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 72 : 35) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 72 : 35) : 0;
            for (int s = 0; s < 6; s++) begin
                random_segment((s % 3 == 0) ? COORD_BITS : 8 + $urandom_range(14));
                random_points(50, (s % 2) ? COORD_BITS : 12 + $urandom_range(12));
                if (s == 2) drain();
            end
            drain();
        end

        // long receiver hold-off while points keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_segment(16);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            random_points(120, 18);
        join
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("point_segment_distance_unit test passed");
        else
            $display("point_segment_distance_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
